[sv/u8dec_pkg.sv]
// Shared types and constants for the UTF-8 to UTF-32 decoder.
`default_nettype none

package u8dec_pkg;

  // Width of one decoded code point
  localparam int unsigned CpWidth = 21;

  // Default depth of the event queue between front and back
  localparam int unsigned QueueDepthDefault = 4;

  // Value sent as byte-order mark
  localparam logic [CpWidth-1:0] MarkValue = 21'h00FEFF;

  // Payload masks for lead bytes of each length and for continuation bytes
  localparam logic [7:0] MaskLead2 = 8'h1F;
  localparam logic [7:0] MaskLead3 = 8'h0F;
  localparam logic [7:0] MaskLead4 = 8'h07;
  localparam logic [7:0] MaskCont  = 8'h3F;

  // Kind of one result word
  typedef enum logic [1:0] {
    KIND_CODE = 2'd0,
    KIND_MARK = 2'd1,
    KIND_BAD  = 2'd2
  } result_kind_t;

  // Class of a byte seen in lead position
  typedef enum logic [2:0] {
    LEAD_SINGLE,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_class_t;

  // One finished event passed from front to back
  typedef struct packed {
    logic [CpWidth-1:0] cp;
    result_kind_t       kind;
    logic               with_mark;
  } event_t;

  // Classify a lead byte by its leading ones
  function automatic lead_class_t classify_lead(input logic [7:0] b);
    lead_class_t c;
    unique casez (b)
      8'b0???????: c = LEAD_SINGLE;
      8'b10??????: c = LEAD_SINGLE;
      8'b110?????: c = LEAD_TWO;
      8'b1110????: c = LEAD_THREE;
      8'b11110???: c = LEAD_FOUR;
      default:     c = LEAD_BAD;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[sv/u8dec_front.sv]
// Front end: accepts bytes, gathers sequences and posts finished events.
`default_nettype none

module u8dec_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write_en,
  input  wire logic               cfg_write_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_byte,
  input  wire logic               queue_full,
  output logic                    push,
  output u8dec_pkg::event_t       push_event
);

  logic [2:0]                       bytes_expected, bytes_expected_next;
  logic [2:0]                       bytes_seen, bytes_seen_next;
  logic [u8dec_pkg::CpWidth-1:0]    bit_accumulator, bit_accumulator_next;
  logic                             mark_sent, mark_sent_next;
  logic                             emit_byte_order_mark;
  logic                             accept;
  logic                             need_mark;
  logic [2:0]                       seen_inc;
  logic [u8dec_pkg::CpWidth-1:0]    acc_shift;
  logic [7:0]                       cont_bits;
  u8dec_pkg::lead_class_t           lead_class;

  assign in_ready   = !queue_full;
  assign accept     = in_valid && in_ready;
  assign need_mark  = !mark_sent && emit_byte_order_mark;
  assign lead_class = u8dec_pkg::classify_lead(in_byte);
  assign seen_inc   = bytes_seen + 3'd1;
  assign cont_bits  = in_byte & u8dec_pkg::MaskCont;
  assign acc_shift  = {bit_accumulator[u8dec_pkg::CpWidth-7:0], cont_bits[5:0]};

  // Decode one byte and decide whether it finishes an event
  always_comb begin
    bytes_expected_next  = bytes_expected;
    bytes_seen_next      = bytes_seen;
    bit_accumulator_next = bit_accumulator;
    mark_sent_next       = mark_sent;
    push                 = 1'b0;
    push_event.cp        = '0;
    push_event.kind      = u8dec_pkg::KIND_CODE;
    push_event.with_mark = 1'b0;
    if (accept) begin
      if (bytes_expected == 3'd0) begin
        unique case (lead_class)
          u8dec_pkg::LEAD_SINGLE: begin
            push                 = 1'b1;
            push_event.cp        = {{(u8dec_pkg::CpWidth-8){1'b0}}, in_byte};
            push_event.with_mark = need_mark;
            mark_sent_next       = 1'b1;
          end
          u8dec_pkg::LEAD_TWO: begin
            bytes_expected_next  = 3'd2;
            bytes_seen_next      = 3'd1;
            bit_accumulator_next = {{(u8dec_pkg::CpWidth-8){1'b0}},
                                    in_byte & u8dec_pkg::MaskLead2};
          end
          u8dec_pkg::LEAD_THREE: begin
            bytes_expected_next  = 3'd3;
            bytes_seen_next      = 3'd1;
            bit_accumulator_next = {{(u8dec_pkg::CpWidth-8){1'b0}},
                                    in_byte & u8dec_pkg::MaskLead3};
          end
          u8dec_pkg::LEAD_FOUR: begin
            bytes_expected_next  = 3'd4;
            bytes_seen_next      = 3'd1;
            bit_accumulator_next = {{(u8dec_pkg::CpWidth-8){1'b0}},
                                    in_byte & u8dec_pkg::MaskLead4};
          end
          default: begin
            push            = 1'b1;
            push_event.kind = u8dec_pkg::KIND_BAD;
          end
        endcase
      end else if (seen_inc >= bytes_expected) begin
        // close the sequence
        push                 = 1'b1;
        push_event.cp        = acc_shift;
        push_event.with_mark = need_mark;
        mark_sent_next       = 1'b1;
        bytes_expected_next  = 3'd0;
        bytes_seen_next      = 3'd0;
        bit_accumulator_next = '0;
      end else begin
        bytes_seen_next      = seen_inc;
        bit_accumulator_next = acc_shift;
      end
    end
  end

  // Hold sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_expected  <= 3'd0;
      bytes_seen      <= 3'd0;
      bit_accumulator <= '0;
      mark_sent       <= 1'b0;
    end else begin
      bytes_expected  <= bytes_expected_next;
      bytes_seen      <= bytes_seen_next;
      bit_accumulator <= bit_accumulator_next;
      mark_sent       <= mark_sent_next;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_byte_order_mark <= 1'b1;
    end else if (cfg_write_en) begin
      emit_byte_order_mark <= cfg_write_data;
    end
  end

endmodule

`default_nettype wire

[sv/u8dec_queue.sv]
// Small event queue between the front and back ends.
`default_nettype none

module u8dec_queue #(
  parameter int unsigned Depth = u8dec_pkg::QueueDepthDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire u8dec_pkg::event_t  push_event,
  input  wire logic               pop,
  output logic                    full,
  output logic                    not_empty,
  output u8dec_pkg::event_t       head
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  u8dec_pkg::event_t entries [Depth];
  logic [PtrW-1:0]   wr_ptr, rd_ptr;
  logic [CntW-1:0]   count;
  logic              do_push, do_pop;

  assign full      = (count == CntW'(Depth));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = entries[rd_ptr];

  // Write storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_event;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[sv/u8dec_back.sv]
// Back end: expands events into result words on the output register.
`default_nettype none

module u8dec_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          head_valid,
  input  wire u8dec_pkg::event_t             head,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [u8dec_pkg::CpWidth-1:0]      code_point,
  output logic [1:0]                         result_kind,
  output logic                               last_of_run
);

  logic                    load;
  logic                    mark_done;
  logic                    issue_mark;

  assign load       = !out_valid || out_ready;
  assign issue_mark = head.with_mark && !mark_done;
  assign pop        = load && head_valid && !issue_mark;

  // Output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      mark_done <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        mark_done <= issue_mark;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      if (issue_mark) begin
        code_point  <= u8dec_pkg::MarkValue;
        result_kind <= u8dec_pkg::KIND_MARK;
        last_of_run <= 1'b0;
      end else begin
        code_point  <= head.cp;
        result_kind <= head.kind;
        last_of_run <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[sv/utf8_to_utf32_decoder.sv]
// Top level of the UTF-8 to UTF-32 decoder.
//
//   channel  | handshake                  | words
//   ---------+----------------------------+----------------------------------------
//   input    | in_valid / in_ready        | in_byte
//   output   | out_valid / out_ready      | code_point, result_kind, last_of_run
//   config   | cfg_write_en (no wait)     | cfg_write_data (byte-order mark enable)
//
// One byte is taken every cycle while the event queue has room; a finished
// code point passes through the event queue to the output register.
// The one-time mark is an extra output word ahead of the first code point, absorbed by the queue.
// Reset is synchronous and clears the sequence state, queue and output valid.
// Input stalls only when the queue (QueueDepth events) is full.
`default_nettype none

module utf8_to_utf32_decoder #(
  parameter int unsigned QueueDepth = u8dec_pkg::QueueDepthDefault
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write_en,
  input  wire logic                          cfg_write_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [u8dec_pkg::CpWidth-1:0]      code_point,
  output logic [1:0]                         result_kind,
  output logic                               last_of_run
);

  logic              push, pop, full, not_empty;
  u8dec_pkg::event_t push_event, head;

  u8dec_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .queue_full     (full),
    .push           (push),
    .push_event     (push_event)
  );

  u8dec_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_event (push_event),
    .pop        (pop),
    .full       (full),
    .not_empty  (not_empty),
    .head       (head)
  );

  u8dec_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (not_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_point  (code_point),
    .result_kind (result_kind),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire
